FILE: src/spq_pkg.sv
// Shared types, codes and helpers for the sorted priority queue.
package spq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int PRIO_W    = 8;
  localparam int DATA_W    = 32;
  localparam int IN_DW     = 40;
  localparam int OUT_DW    = 56;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_REM_EQ = 2'd2,
    OP_REM_LE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_PUSH_CMP,
    S_PUSH_HEAD,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct packed {
    logic   we;
    logic   re;
    entry_t wdata;
  } mem_req_t;

  // counts are reported modulo 32
  function automatic logic [4:0] cnt5(input logic [31:0] v);
    return v[4:0];
  endfunction

endpackage

FILE: src/spq_store.sv
// Entry memory: one write port, one read port with registered read data.
module spq_store
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  mem_req_t         req,
  input  logic [IDX_W-1:0] waddr,
  input  logic [IDX_W-1:0] raddr,
  output entry_t           rd_data
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[raddr];
    end
  end

endmodule

FILE: src/sorted_priority_queue.sv
// Sorted priority queue: top level with the operation sequencer.
//
// Holds up to DEPTH entries (8-bit priority, 32-bit data) in ascending
// priority order, equal priorities in arrival order. One request beat on
// the in_ channel carries an opcode in in_tuser (push, pop, remove equal,
// remove at or below) with the key and data word in in_tdata. Each request
// gives exactly one result beat on the out_ channel: status in out_tuser,
// popped entry, removed count and occupancy in out_tdata.
// A push walks from the tail toward the head through the single memory
// read port, moving each entry of greater priority up one place, one entry
// per cycle. Pop and removals compact the store in one pass of one entry
// per cycle. A full push, a push into an empty queue or an operation on an
// empty queue goes from S_START straight to S_DONE. One request is in
// flight at a time; in_tready is high only when the sequencer is idle, so a
// new request is not accepted until the previous one has left the sequencer.
// The result sits in an output register, so a new request may be taken
// while the previous result waits; if the receiver stalls, the next result
// waits in the sequencer. Reset (rst_n low, synchronous) empties the queue
// and drops any pending result; the memory itself is not cleared.
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // priority_req[7:0], payload[39:8]
  input  logic [1:0]        in_tuser,   // opcode[1:0]
  output logic              out_tvalid,
  input  logic              out_tready,
  // head_data[31:0], head_priority[39:32], removed_count[44:40],
  // occupancy[49:45], zero fill[55:50]
  output logic [OUT_DW-1:0] out_tdata,
  output logic [1:0]        out_tuser   // status[1:0]
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic [PRIO_W-1:0] key_r, key_nxt;
  logic [DATA_W-1:0] word_r, word_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [IDX_W-1:0]  hole_r, hole_nxt;
  logic [IDX_W-1:0]  scan_r, scan_nxt;
  logic [CNT_W-1:0]  wr_r, wr_nxt;
  logic [CNT_W-1:0]  removed_r, removed_nxt;
  status_t           status_r, status_nxt;
  logic [DATA_W-1:0] hdata_r, hdata_nxt;
  logic [PRIO_W-1:0] hprio_r, hprio_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [OUT_DW-1:0] out_data_r, out_data_nxt;
  logic [1:0]        out_user_r, out_user_nxt;

  mem_req_t         req;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           rd_data;

  logic             in_acc;
  logic             full, empty;
  logic             prio_gt;
  logic             drop;
  logic             scan_more;
  logic [CNT_W-1:0] scan_inc;
  logic             out_free;
  entry_t           new_entry;

  spq_store #(
    .DEPTH (DEPTH),
    .IDX_W (IDX_W)
  ) u_store (
    .clk     (clk),
    .req     (req),
    .waddr   (waddr),
    .raddr   (raddr),
    .rd_data (rd_data)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_acc     = in_tvalid & in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign empty     = (count_r == '0);
  assign prio_gt   = (rd_data.prio > key_r);
  assign scan_inc  = CNT_W'(scan_r) + CNT_W'(1);
  assign scan_more = (scan_inc < count_r);
  assign out_free  = ~out_valid_r | out_tready;
  assign new_entry = '{prio: key_r, data: word_r};

  always_comb begin
    case (op_r)
      OP_POP:    drop = (scan_r == '0);
      OP_REM_EQ: drop = (rd_data.prio == key_r);
      OP_REM_LE: drop = (rd_data.prio <= key_r);
      default:   drop = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) state_nxt = S_START;
      end
      S_START: begin
        if (op_r == OP_PUSH) begin
          state_nxt = (full || empty) ? S_DONE : S_PUSH_CMP;
        end else begin
          state_nxt = empty ? S_DONE : S_SCAN;
        end
      end
      S_PUSH_CMP: begin
        if (!prio_gt) begin
          state_nxt = S_DONE;
        end else if (hole_r == IDX_W'(1)) begin
          state_nxt = S_PUSH_HEAD;
        end
      end
      S_PUSH_HEAD: state_nxt = S_DONE;
      S_SCAN: begin
        if (!scan_more) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath, memory control and result register
  always_comb begin
    op_nxt        = op_r;
    key_nxt       = key_r;
    word_nxt      = word_r;
    count_nxt     = count_r;
    hole_nxt      = hole_r;
    scan_nxt      = scan_r;
    wr_nxt        = wr_r;
    removed_nxt   = removed_r;
    status_nxt    = status_r;
    hdata_nxt     = hdata_r;
    hprio_nxt     = hprio_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    req           = '0;
    waddr         = '0;
    raddr         = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          op_nxt      = op_t'(in_tuser);
          key_nxt     = in_tdata[7:0];
          word_nxt    = in_tdata[39:8];
          status_nxt  = STAT_OK;
          hdata_nxt   = '0;
          hprio_nxt   = '0;
          removed_nxt = '0;
          wr_nxt      = '0;
          scan_nxt    = '0;
        end
      end
      S_START: begin
        if (op_r == OP_PUSH) begin
          if (full) begin
            status_nxt = STAT_FULL;
          end else if (empty) begin
            req.we    = 1'b1;
            req.wdata = new_entry;
            waddr     = '0;
            count_nxt = count_r + CNT_W'(1);
          end else begin
            // hole starts just past the tail
            req.re   = 1'b1;
            raddr    = IDX_W'(count_r - CNT_W'(1));
            hole_nxt = IDX_W'(count_r);
          end
        end else begin
          if (empty) begin
            status_nxt = STAT_EMPTY;
          end else begin
            req.re = 1'b1;
            raddr  = '0;
          end
        end
      end
      S_PUSH_CMP: begin
        // rd_data holds the entry just below the hole
        req.we = 1'b1;
        waddr  = hole_r;
        if (prio_gt) begin
          req.wdata = rd_data;
          hole_nxt  = hole_r - IDX_W'(1);
          if (hole_r != IDX_W'(1)) begin
            req.re = 1'b1;
            raddr  = hole_r - IDX_W'(2);
          end
        end else begin
          req.wdata = new_entry;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      S_PUSH_HEAD: begin
        req.we    = 1'b1;
        req.wdata = new_entry;
        waddr     = '0;
        count_nxt = count_r + CNT_W'(1);
      end
      S_SCAN: begin
        // compaction: kept entries slide down to the write pointer
        if (drop) begin
          removed_nxt = removed_r + CNT_W'(1);
          if (op_r == OP_POP) begin
            hdata_nxt = rd_data.data;
            hprio_nxt = rd_data.prio;
          end
        end else begin
          req.we    = 1'b1;
          req.wdata = rd_data;
          waddr     = wr_r[IDX_W-1:0];
          wr_nxt    = wr_r + CNT_W'(1);
        end
        if (scan_more) begin
          req.re   = 1'b1;
          raddr    = IDX_W'(scan_inc);
          scan_nxt = IDX_W'(scan_inc);
        end else begin
          count_nxt = drop ? wr_r : wr_r + CNT_W'(1);
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = status_r;
          out_data_nxt  = {6'd0, cnt5(32'(count_r)), cnt5(32'(removed_r)),
                           hprio_r, hdata_r};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    key_r      <= key_nxt;
    word_r     <= word_nxt;
    hole_r     <= hole_nxt;
    scan_r     <= scan_nxt;
    wr_r       <= wr_nxt;
    removed_r  <= removed_nxt;
    status_r   <= status_nxt;
    hdata_r    <= hdata_nxt;
    hprio_r    <= hprio_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

FILE: src/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker
  import spq_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic [1:0]        out_tuser
);

  // one request at a time: the sequencer is busy right after an accepted beat
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("in_tready high right after an accepted request beat");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result beat changed or dropped");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_EMPTY |->
      out_tdata[49:40] == 10'd0 && out_tdata[39:0] == 40'd0)
    else $error("empty status with nonzero removal, head or occupancy");

  a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == STAT_FULL |-> out_tdata[44:0] == 45'd0)
    else $error("full status with nonzero removal or head fields");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      (out_tuser == STAT_OK || out_tuser == STAT_EMPTY || out_tuser == STAT_FULL) &&
      out_tdata[55:50] == 6'd0)
    else $error("bad status code or nonzero fill bits");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
